// ===== rtl/msc_pkg.sv =====
// Shared constants and types for the magnetometer sample calibration block.
`default_nettype none

package msc_pkg;

   // Field widths fixed by the sensor word format.
   localparam int BYTE_W    = 8;
   localparam int AXIS_W    = 18;                 // offset-binary axis value
   localparam int CORR_W    = AXIS_W + 1;         // signed axis after bias and offset
   localparam int OFF_W     = 18;                 // hard-iron offset register
   localparam int WREG_W    = 48;                 // packed weight row register
   localparam int OUT_W     = 22;                 // calibrated field
   localparam int NUM_AXES  = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = WREG_W;

   // Offset-binary midpoint of an 18-bit axis.
   localparam logic [CORR_W-1:0] AXIS_BIAS = CORR_W'(131072);

   // Register indexes on the csr port.
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_Z  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHTS_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHTS_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHTS_Z = 3'd5;

   typedef logic signed [CORR_W-1:0] corr_type;
   typedef logic signed [OUT_W-1:0]  field_type;

   // Stage advance strobes handed from the top-level pipeline control to each row.
   typedef struct packed {
      logic adv_mul;
      logic adv_sum;
   } stage_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/msc_if.sv =====
// Valid/ready channel interfaces for raw sensor words and calibrated field words.
`default_nettype none

interface msc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] x_high;
   logic [7:0] x_mid;
   logic [7:0] y_high;
   logic [7:0] y_mid;
   logic [7:0] z_high;
   logic [7:0] z_mid;
   logic [7:0] low_bits;

   modport source (output valid, x_high, x_mid, y_high, y_mid, z_high, z_mid, low_bits,
                   input ready);
   modport sink   (input valid, x_high, x_mid, y_high, y_mid, z_high, z_mid, low_bits,
                   output ready);
endinterface

interface msc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [21:0] field_x;
   logic signed [21:0] field_y;
   logic signed [21:0] field_z;

   modport source (output valid, field_x, field_y, field_z, input ready);
   modport sink   (input valid, field_x, field_y, field_z, output ready);
endinterface

`default_nettype wire

// ===== rtl/msc_row.sv =====
// One calibration matrix row: three registered products, then a registered sum and shift.
`default_nettype none

module msc_row #(
   parameter int COEF_WIDTH     = 16,
   parameter int COEF_FRAC_BITS = 14
) (
   input  wire                          clock,
   input  wire msc_pkg::stage_ctl_type  ctl,
   input  wire msc_pkg::corr_type       axis [msc_pkg::NUM_AXES],
   input  wire [msc_pkg::WREG_W-1:0]    weights,
   output msc_pkg::field_type           field
);
   import msc_pkg::*;

   localparam int WEXT_W = (NUM_AXES * COEF_WIDTH > WREG_W) ? NUM_AXES * COEF_WIDTH : WREG_W;
   localparam int PROD_W = CORR_W + COEF_WIDTH;
   localparam int SUM_W  = PROD_W + 2;
   localparam int ACC_W  = (SUM_W > COEF_FRAC_BITS + OUT_W) ? SUM_W : COEF_FRAC_BITS + OUT_W;

   logic [WEXT_W-1:0]             wext;
   logic signed [COEF_WIDTH-1:0]  coef    [NUM_AXES];
   logic signed [PROD_W-1:0]      prod_in [NUM_AXES];
   logic signed [PROD_W-1:0]      prod_ff [NUM_AXES];
   logic signed [ACC_W-1:0]       acc;
   field_type                     field_in;
   field_type                     field_ff;

   // Slots past the register top read as zero.
   assign wext = WEXT_W'(weights);

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         coef[i]    = signed'(wext[i*COEF_WIDTH +: COEF_WIDTH]);
         prod_in[i] = PROD_W'(axis[i]) * PROD_W'(coef[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.adv_mul) begin
         prod_ff <= prod_in;
      end
   end

   // Arithmetic shift right by the fraction bits, keep the low field bits.
   always_comb begin
      acc      = ACC_W'(prod_ff[0]) + ACC_W'(prod_ff[1]) + ACC_W'(prod_ff[2]);
      field_in = acc[COEF_FRAC_BITS +: OUT_W];
   end

   always_ff @(posedge clock) begin
      if (ctl.adv_sum) begin
         field_ff <= field_in;
      end
   end

   assign field = field_ff;

endmodule

`default_nettype wire

// ===== rtl/magnetometer_sample_calibrate.sv =====
// Top level of the magnetometer sample calibration pipeline.
// Usage:
//   req_bus carries one raw 3-axis sensor word: high and middle bytes per axis plus
//   a byte of packed low bits. rsp_bus returns one word per request with the
//   calibrated x, y and z field in counts (163.84 counts per microtesla).
//   csr_we/csr_index/csr_wdata write hard-iron offsets (index 0..2) and the three
//   packed Q-format weight rows (index 3..5); other indexes are dropped.
//   Write registers only while the pipeline is empty.
// Timing:
//   Three register stages: axis assembly and offset subtract, nine parallel
//   products, row sum and shift into the output register. Each word passes the
//   axis, product and output registers. One word per cycle is sustained while rsp_bus
//   ready is high; the product stage (19 by COEF_WIDTH bit multipliers) sets the clock.
// Reset:
//   Synchronous, active high. Empties the pipeline, clears the offsets and loads
//   the identity matrix into the weight rows.
// Stall:
//   Each stage holds while the stage after it is full and stalled, so bubbles
//   are squeezed out and the request side keeps taking words until all three
//   stages hold data. Nothing is dropped or repeated.
`default_nettype none

module magnetometer_sample_calibrate #(
   parameter int COEF_WIDTH     = 16,
   parameter int COEF_FRAC_BITS = 14
) (
   input  wire                            clock,
   input  wire                            reset,
   msc_req_if.sink                        req_bus,
   msc_rsp_if.source                      rsp_bus,
   input  wire                            csr_we,
   input  wire [msc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire [msc_pkg::CSR_DAT_W-1:0]   csr_wdata
);
   import msc_pkg::*;

   localparam int RST_W = COEF_FRAC_BITS + 2 * COEF_WIDTH + 1;
   localparam logic [WREG_W-1:0] WRST_X = WREG_W'(RST_W'(1) << COEF_FRAC_BITS);
   localparam logic [WREG_W-1:0] WRST_Y = WREG_W'(RST_W'(1) << (COEF_FRAC_BITS + COEF_WIDTH));
   localparam logic [WREG_W-1:0] WRST_Z =
      WREG_W'(RST_W'(1) << (COEF_FRAC_BITS + 2 * COEF_WIDTH));

   // Configuration registers.
   logic [OFF_W-1:0]  off_ff   [NUM_AXES];
   logic [WREG_W-1:0] wrow_ff  [NUM_AXES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            off_ff[i] <= '0;
         end
         wrow_ff[0] <= WRST_X;
         wrow_ff[1] <= WRST_Y;
         wrow_ff[2] <= WRST_Z;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_OFFSET_X:  off_ff[0]  <= csr_wdata[OFF_W-1:0];
            CSR_OFFSET_Y:  off_ff[1]  <= csr_wdata[OFF_W-1:0];
            CSR_OFFSET_Z:  off_ff[2]  <= csr_wdata[OFF_W-1:0];
            CSR_WEIGHTS_X: wrow_ff[0] <= csr_wdata[WREG_W-1:0];
            CSR_WEIGHTS_Y: wrow_ff[1] <= csr_wdata[WREG_W-1:0];
            CSR_WEIGHTS_Z: wrow_ff[2] <= csr_wdata[WREG_W-1:0];
            default: ;
         endcase
      end
   end

   // Pipeline occupancy: axis stage, product stage, output stage.
   logic v_axis_ff, v_mul_ff, v_out_ff;
   logic v_axis_in, v_mul_in, v_out_in;
   logic rdy_axis, rdy_mul, rdy_out;
   stage_ctl_type ctl;

   // A stage may load when it is empty or its contents move on this cycle.
   assign rdy_out  = !v_out_ff  || rsp_bus.ready;
   assign rdy_mul  = !v_mul_ff  || rdy_out;
   assign rdy_axis = !v_axis_ff || rdy_mul;

   assign v_axis_in = rdy_axis ? req_bus.valid : v_axis_ff;
   assign v_mul_in  = rdy_mul  ? v_axis_ff     : v_mul_ff;
   assign v_out_in  = rdy_out  ? v_mul_ff      : v_out_ff;

   assign ctl.adv_mul = rdy_mul && v_axis_ff;
   assign ctl.adv_sum = rdy_out && v_mul_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_axis_ff <= 1'b0;
         v_mul_ff  <= 1'b0;
         v_out_ff  <= 1'b0;
      end else begin
         v_axis_ff <= v_axis_in;
         v_mul_ff  <= v_mul_in;
         v_out_ff  <= v_out_in;
      end
   end

   // Axis stage: assemble offset-binary value, remove bias and hard-iron offset.
   logic [AXIS_W-1:0] raw      [NUM_AXES];
   corr_type          axis_in  [NUM_AXES];
   corr_type          axis_ff  [NUM_AXES];

   always_comb begin
      raw[0] = {req_bus.x_high, req_bus.x_mid, req_bus.low_bits[7:6]};
      raw[1] = {req_bus.y_high, req_bus.y_mid, req_bus.low_bits[5:4]};
      raw[2] = {req_bus.z_high, req_bus.z_mid, req_bus.low_bits[3:2]};
      for (int i = 0; i < NUM_AXES; i++) begin
         // The exact difference always fits the signed width, so wrap is harmless.
         axis_in[i] = {1'b0, raw[i]} - AXIS_BIAS - {off_ff[i][OFF_W-1], off_ff[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_axis && req_bus.valid) begin
         axis_ff <= axis_in;
      end
   end

   // Product and sum stages, one matrix row each.
   field_type field [NUM_AXES];

   for (genvar r = 0; r < NUM_AXES; r++) begin : g_row
      msc_row #(
         .COEF_WIDTH     (COEF_WIDTH),
         .COEF_FRAC_BITS (COEF_FRAC_BITS)
      ) u_row (
         .clock   (clock),
         .ctl     (ctl),
         .axis    (axis_ff),
         .weights (wrow_ff[r]),
         .field   (field[r])
      );
   end

   assign req_bus.ready   = rdy_axis;
   assign rsp_bus.valid   = v_out_ff;
   assign rsp_bus.field_x = field[0];
   assign rsp_bus.field_y = field[1];
   assign rsp_bus.field_z = field[2];

endmodule

`default_nettype wire
